// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the encoder run tracker (qdre_run)
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/qdre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdre_pkg
// Types and constants of the quantized delta run encoder
// ----------------------------------------------------------------------------
package qdre_pkg;

  localparam int MAX_VERTICES = 65536;
  localparam int CNT_W        = $clog2(MAX_VERTICES);
  localparam logic [CNT_W-1:0] VERTEX_LIMIT = CNT_W'(MAX_VERTICES - 1);

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int CLAMP_W = 19;
  localparam int PROD_W  = 27;
  localparam int DELTA_W = 8;
  localparam int IDX_W   = 16;
  localparam int LEN_W   = 16;

  // clamp window is +/- 2.0 in Q.16
  localparam logic signed [DIFF_W-1:0]  CLAMP_HI    = 25'sd131072;
  localparam logic signed [DIFF_W-1:0]  CLAMP_LO    = -25'sd131072;
  localparam logic signed [PROD_W-1:0]  QUANT_SCALE = 27'sd127;
  localparam logic signed [PROD_W-1:0]  QUANT_ROUND = 27'sd65536;
  localparam int                        QUANT_SHIFT = 17;
  localparam logic signed [PROD_W-1:0]  TRUNC_BIAS  = 27'sd131071;

  // output queue depth, power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int S_TDATA_W = 144;
  localparam int M_TDATA_W = 80;

  typedef struct packed {
    logic             has_vertex;
    logic [IDX_W-1:0] vertex_index;
    logic [IDX_W-1:0] run_start;
    logic [DELTA_W-1:0] delta_x;
    logic [DELTA_W-1:0] delta_y;
    logic [DELTA_W-1:0] delta_z;
    logic             run_end;
    logic [LEN_W-1:0] run_length;
    logic             frame_done;
  } result_t;

  // results handed to the output queue by one processed vertex
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// ===== design/qdre_quant.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdre_quant
// One axis: difference, clamp to +/-2.0, scale by 127/2^17 plus a half-step offset, truncate toward zero
// ----------------------------------------------------------------------------
module qdre_quant (
  input  logic signed [qdre_pkg::COORD_W-1:0] pos,
  input  logic signed [qdre_pkg::COORD_W-1:0] base,
  output logic signed [qdre_pkg::DELTA_W-1:0] q
);
  import qdre_pkg::*;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [CLAMP_W-1:0] clamped;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  biased;

  always_comb begin
    diff = DIFF_W'(pos) - DIFF_W'(base);
    if (diff > CLAMP_HI) begin
      clamped = CLAMP_W'(CLAMP_HI);
    end else if (diff < CLAMP_LO) begin
      clamped = CLAMP_W'(CLAMP_LO);
    end else begin
      clamped = diff[CLAMP_W-1:0];
    end
    prod = PROD_W'(clamped) * QUANT_SCALE + QUANT_ROUND;
    // shift rounds down, so bias negatives to get truncation toward zero
    biased = prod[PROD_W-1] ? prod + TRUNC_BIAS : prod;
    q = biased[QUANT_SHIFT+DELTA_W-1:QUANT_SHIFT];
  end

endmodule

// ===== design/qdre_run.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdre_run
// Run tracking: holds one vertex back and forms up to two results per vertex
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qdre_run (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              proc,
  input  logic [3*qdre_pkg::DELTA_W-1:0]    deltas,
  input  logic                              frame_end,
  output qdre_pkg::push_t                   push
);
  import qdre_pkg::*;

  logic [CNT_W-1:0]       vertex_counter, vertex_counter_next;
  logic                   in_run, in_run_next;
  logic [CNT_W-1:0]       current_run_start, current_run_start_next;
  logic [LEN_W-1:0]       current_run_length, current_run_length_next;
  logic                   held_valid, held_valid_next;
  logic [3*DELTA_W-1:0]   held_deltas, held_deltas_next;
  logic [CNT_W-1:0]       held_index, held_index_next;

  logic    active;
  logic    nonzero;
  logic    emit_a;
  result_t res_a;
  result_t res_b;

  function automatic result_t make_result(
    input logic             hv,
    input logic [CNT_W-1:0] idx,
    input logic [CNT_W-1:0] rs,
    input logic [3*DELTA_W-1:0] d,
    input logic             re,
    input logic [LEN_W-1:0] rl
  );
    result_t r;
    r.has_vertex   = hv;
    r.vertex_index = IDX_W'(idx);
    r.run_start    = IDX_W'(rs);
    r.delta_x      = d[DELTA_W-1:0];
    r.delta_y      = d[2*DELTA_W-1:DELTA_W];
    r.delta_z      = d[3*DELTA_W-1:2*DELTA_W];
    r.run_end      = re;
    r.run_length   = re ? rl : '0;
    r.frame_done   = 1'b0;
    return r;
  endfunction

  always_comb begin
    active  = vertex_counter < VERTEX_LIMIT;
    nonzero = deltas != '0;

    vertex_counter_next     = vertex_counter;
    in_run_next             = in_run;
    current_run_start_next  = current_run_start;
    current_run_length_next = current_run_length;
    held_valid_next         = held_valid;
    held_deltas_next        = held_deltas;
    held_index_next         = held_index;

    emit_a = 1'b0;
    res_a  = make_result(1'b1, held_index, current_run_start, held_deltas,
                         !nonzero, current_run_length);

    if (active) begin
      emit_a = held_valid;
      if (nonzero) begin
        if (!in_run) begin
          in_run_next             = 1'b1;
          current_run_start_next  = vertex_counter;
          current_run_length_next = LEN_W'(1);
        end else begin
          current_run_length_next = current_run_length + LEN_W'(1);
        end
        held_valid_next  = 1'b1;
        held_deltas_next = deltas;
        held_index_next  = vertex_counter;
      end else begin
        held_valid_next = 1'b0;
        in_run_next     = 1'b0;
      end
      vertex_counter_next = vertex_counter + CNT_W'(1);
    end

    // flush result: the vertex still held, or an empty frame marker
    res_b = held_valid_next
          ? make_result(1'b1, held_index_next, current_run_start_next,
                        held_deltas_next, 1'b1, current_run_length_next)
          : make_result(1'b0, '0, '0, '0, 1'b0, '0);
    res_b.frame_done = 1'b1;

    push.res0  = res_a;
    push.res1  = res_b;
    push.count = 2'd0;
    if (proc) begin
      if (frame_end) begin
        if (emit_a && held_valid_next) begin
          push.count = 2'd2;
        end else if (emit_a) begin
          push.res0.frame_done = 1'b1;
          push.count = 2'd1;
        end else begin
          push.res0  = res_b;
          push.count = 2'd1;
        end
      end else begin
        push.count = emit_a ? 2'd1 : 2'd0;
      end
    end

    if (frame_end) begin
      vertex_counter_next     = '0;
      in_run_next             = 1'b0;
      current_run_start_next  = '0;
      current_run_length_next = '0;
      held_valid_next         = 1'b0;
      held_deltas_next        = '0;
      held_index_next         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_counter     <= '0;
      in_run             <= 1'b0;
      current_run_start  <= '0;
      current_run_length <= '0;
      held_valid         <= 1'b0;
      held_deltas        <= '0;
      held_index         <= '0;
    end else if (proc) begin
      vertex_counter     <= vertex_counter_next;
      in_run             <= in_run_next;
      current_run_start  <= current_run_start_next;
      current_run_length <= current_run_length_next;
      held_valid         <= held_valid_next;
      held_deltas        <= held_deltas_next;
      held_index         <= held_index_next;
    end
  end

  `ASSERT_ALWAYS(a_held_tracks_run, clk, rst, held_valid == in_run, "held vertex and run flag disagree")
  `ASSERT_IMPL(a_pair_shape, clk, rst, push.count == 2'd2, push.res0.has_vertex && !push.res0.run_end && push.res1.run_end && push.res1.frame_done, "two-result transaction malformed")
  `ASSERT_NEXT(a_frame_clears, clk, rst, proc && frame_end, vertex_counter == '0 && !held_valid, "state not cleared after frame end")

endmodule

// ===== design/qdre_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdre_outq
// Small result queue: up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module qdre_outq (
  input  logic              clk,
  input  logic              rst,
  input  qdre_pkg::push_t   push,
  output logic              room,
  output logic              pop_valid,
  input  logic              pop_ready,
  output qdre_pkg::result_t pop_data
);
  import qdre_pkg::*;

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              pop;

  assign pop_valid = count != '0;
  assign pop_data  = entries[rd_ptr];
  assign pop       = pop_valid && pop_ready;
  // space for a full two-result transaction
  assign room      = count <= (QPTR_W+1)'(QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(push.count) - (QPTR_W+1)'(pop);
    end
  end

endmodule

// ===== design/quantized_delta_run_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_delta_run_encoder_core
// Quantizes vertex deltas and emits nonzero vertices as indexed runs
// ----------------------------------------------------------------------------
// path: the vertex that releases a result is registered in the input stage,
//   then its results are written to the result queue; throughput: one vertex
//   per cycle while the 4-entry result queue has room for two results
// reset: rst synchronous active high, clears counter, run state and queue
module quantized_delta_run_encoder_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pos_x, pos_y, pos_z, base_x, base_y, base_z
  input  logic [qdre_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // vertex_index, run_start, delta_x, delta_y, delta_z, run_end, run_length
  output logic [qdre_pkg::M_TDATA_W-1:0]    m_tdata,
  // has_vertex
  output logic                              m_tuser,
  output logic                              m_tlast
);
  import qdre_pkg::*;

  logic signed [DELTA_W-1:0] qx, qy, qz;
  logic                      s1_valid;
  logic [3*DELTA_W-1:0]      s1_deltas;
  logic                      s1_last;
  logic                      proc;
  logic                      room;
  push_t                     push;
  result_t                   head;

  qdre_quant u_quant_x (
    .pos (s_tdata[COORD_W-1:0]),
    .base(s_tdata[4*COORD_W-1:3*COORD_W]),
    .q   (qx)
  );

  qdre_quant u_quant_y (
    .pos (s_tdata[2*COORD_W-1:COORD_W]),
    .base(s_tdata[5*COORD_W-1:4*COORD_W]),
    .q   (qy)
  );

  qdre_quant u_quant_z (
    .pos (s_tdata[3*COORD_W-1:2*COORD_W]),
    .base(s_tdata[6*COORD_W-1:5*COORD_W]),
    .q   (qz)
  );

  assign proc     = s1_valid && room;
  assign s_tready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_deltas <= {qz, qy, qx};
      s1_last   <= s_tlast;
    end
  end

  qdre_run u_run (
    .clk      (clk),
    .rst      (rst),
    .proc     (proc),
    .deltas   (s1_deltas),
    .frame_end(s1_last),
    .push     (push)
  );

  qdre_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .pop_valid(m_tvalid),
    .pop_ready(m_tready),
    .pop_data (head)
  );

  assign m_tdata = {7'd0, head.run_length, head.run_end, head.delta_z, head.delta_y,
                    head.delta_x, head.run_start, head.vertex_index};
  assign m_tuser = head.has_vertex;
  assign m_tlast = head.frame_done;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quantized_delta_run_encoder_core: a queue-fed
// driver streams vertices, an internal encoder predicts the emitted runs,
// and a monitor compares every result transaction field by field
// ----------------------------------------------------------------------------
module testbench;
  import qdre_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PER_PHASE = 670;
  localparam int COORD_MIN = -8388608;
  localparam int COORD_MAX = 8388607;

  typedef struct packed {
    logic                 last;
    logic [S_TDATA_W-1:0] data;
  } vertex_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  vertex_t pending_vertices[$];
  result_t want_results[$];
  vertex_t in_flight;
  result_t oldest;
  int      send_idle = 0;
  int      recv_stall = 0;
  int      errors = 0;
  int      quiet = 0;

  // encoder state mirrored by the predictor
  logic [IDX_W-1:0]     enc_count;
  logic                 enc_in_run;
  logic [IDX_W-1:0]     run_first;
  logic [LEN_W-1:0]     run_len;
  logic                 held_ok;
  logic [3*DELTA_W-1:0] held_q;
  logic [IDX_W-1:0]     held_idx;

  quantized_delta_run_encoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DELTA_W-1:0] quantize_axis(logic signed [COORD_W-1:0] p,
                                                       logic signed [COORD_W-1:0] b);
    longint d;
    longint n;
    d = longint'(p) - longint'(b);
    if (d > 131072) d = 131072;
    else if (d < -131072) d = -131072;
    n = 127 * d + 65536;
    // longint division truncates toward zero
    return DELTA_W'(n / 131072);
  endfunction

  function automatic result_t make_result(logic hv, logic [IDX_W-1:0] idx,
                                          logic [IDX_W-1:0] rs, logic [3*DELTA_W-1:0] q,
                                          logic re, logic [LEN_W-1:0] len);
    result_t r;
    r.has_vertex   = hv;
    r.vertex_index = idx;
    r.run_start    = rs;
    r.delta_x      = q[7:0];
    r.delta_y      = q[15:8];
    r.delta_z      = q[23:16];
    r.run_end      = re;
    r.run_length   = re ? len : '0;
    r.frame_done   = 1'b0;
    return r;
  endfunction

  function automatic void clear_encoder();
    enc_count  = '0;
    enc_in_run = 1'b0;
    run_first  = '0;
    run_len    = '0;
    held_ok    = 1'b0;
    held_q     = '0;
    held_idx   = '0;
  endfunction

  function automatic void encode_vertex(vertex_t v);
    result_t              outs[2];
    int                   n;
    logic [3*DELTA_W-1:0] q;
    logic [IDX_W-1:0]     idx;
    n = 0;
    if (enc_count != VERTEX_LIMIT) begin
      q = {quantize_axis(v.data[71:48], v.data[143:120]),
           quantize_axis(v.data[47:24], v.data[119:96]),
           quantize_axis(v.data[23:0], v.data[95:72])};
      idx = enc_count;
      if (q != '0) begin
        if (held_ok) begin
          outs[n] = make_result(1'b1, held_idx, run_first, held_q, 1'b0, '0);
          n++;
        end
        if (!enc_in_run) begin
          enc_in_run = 1'b1;
          run_first  = idx;
          run_len    = LEN_W'(1);
        end else begin
          run_len = run_len + LEN_W'(1);
        end
        held_ok  = 1'b1;
        held_q   = q;
        held_idx = idx;
      end else if (held_ok) begin
        outs[n] = make_result(1'b1, held_idx, run_first, held_q, 1'b1, run_len);
        n++;
        held_ok    = 1'b0;
        enc_in_run = 1'b0;
      end
      enc_count = idx + IDX_W'(1);
    end
    if (v.last) begin
      if (held_ok) begin
        outs[n] = make_result(1'b1, held_idx, run_first, held_q, 1'b1, run_len);
        n++;
      end
      if (n == 0) begin
        outs[0] = make_result(1'b0, '0, '0, '0, 1'b0, '0);
        n = 1;
      end
      outs[n-1].frame_done = 1'b1;
      clear_encoder();
    end
    for (int i = 0; i < n; i++) want_results.push_back(outs[i]);
  endfunction

  function automatic vertex_t vertex_from_coords(int px, int py, int pz,
                                                 int bx, int by, int bz, bit last);
    vertex_t v;
    v.last = last;
    v.data = {24'(bz), 24'(by), 24'(bx), 24'(pz), 24'(py), 24'(px)};
    return v;
  endfunction

  // base kept clear of the coordinate limits so that pos = base + d fits
  function automatic vertex_t vertex_from_deltas(int dx, int dy, int dz, bit last);
    int bx;
    int by;
    int bz;
    bx = int'($urandom_range(16000000)) - 8000000;
    by = int'($urandom_range(16000000)) - 8000000;
    bz = int'($urandom_range(16000000)) - 8000000;
    return vertex_from_coords(bx + dx, by + dy, bz + dz, bx, by, bz, last);
  endfunction

  function automatic vertex_t noise_vertex(bit last);
    logic [159:0] w;
    vertex_t      v;
    for (int i = 0; i < 5; i++) w[i*32 +: 32] = $urandom;
    v.data = w[S_TDATA_W-1:0];
    v.last = last;
    return v;
  endfunction

  // zero deltas stay inside the band that quantizes to 0
  function automatic int zero_band();
    return int'($urandom_range(2064)) - 1548;
  endfunction

  function automatic int wide_delta();
    return int'($urandom_range(280000)) - 140000;
  endfunction

  task automatic queue_random(int count);
    int  pick;
    bit  last;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      last = (i == count - 1) || ($urandom_range(29) == 0);
      if (pick < 8)
        pending_vertices.push_back(noise_vertex(last));
      else if (pick < 45)
        pending_vertices.push_back(vertex_from_deltas(zero_band(), zero_band(), zero_band(),
                                                      last));
      else
        pending_vertices.push_back(vertex_from_deltas(wide_delta(), wide_delta(),
                                                      zero_band(), last));
    end
  endtask

  task automatic queue_directed();
    // empty frame on coordinate extremes
    pending_vertices.push_back(vertex_from_coords(COORD_MAX, COORD_MIN, COORD_MAX,
                                                  COORD_MAX, COORD_MIN, COORD_MAX, 1));
    // quantizer thresholds, then run closed by a zero vertex
    pending_vertices.push_back(vertex_from_deltas(517, 0, 0, 0));
    pending_vertices.push_back(vertex_from_deltas(0, -1549, 0, 0));
    pending_vertices.push_back(vertex_from_deltas(516, -1548, 516, 0));
    // clamp extremes, run closed by frame end with two results in one step
    pending_vertices.push_back(vertex_from_coords(COORD_MAX, COORD_MIN, COORD_MAX,
                                                  COORD_MIN, COORD_MAX, COORD_MIN, 0));
    pending_vertices.push_back(vertex_from_coords(COORD_MIN, COORD_MAX, COORD_MIN,
                                                  COORD_MAX, COORD_MIN, COORD_MAX, 0));
    pending_vertices.push_back(vertex_from_deltas(131072, -131072, 131071, 1));
    // single vertex frame
    pending_vertices.push_back(vertex_from_deltas(-131073, 0, 131073, 1));
    // run ended by a zero vertex that also ends the frame
    pending_vertices.push_back(vertex_from_deltas(0, 0, 0, 0));
    pending_vertices.push_back(vertex_from_deltas(0, 0, 0, 0));
    pending_vertices.push_back(vertex_from_deltas(3000, 0, -3000, 0));
    pending_vertices.push_back(vertex_from_deltas(0, 70000, 0, 0));
    pending_vertices.push_back(vertex_from_deltas(0, 0, 0, 1));
    // back to back empty frames
    pending_vertices.push_back(vertex_from_deltas(0, 0, 0, 1));
    pending_vertices.push_back(vertex_from_deltas(-1000, 200, 0, 1));
    // two runs in one frame
    pending_vertices.push_back(vertex_from_deltas(0, 0, -20000, 0));
    pending_vertices.push_back(vertex_from_deltas(0, 0, 0, 0));
    pending_vertices.push_back(vertex_from_deltas(90000, 90000, 90000, 0));
    pending_vertices.push_back(vertex_from_deltas(-90000, -90000, -90000, 1));
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() != 0 || s_tvalid || want_results.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
      clear_encoder();
    end else begin
      if (s_tvalid && s_tready) encode_vertex(in_flight);
      if (!s_tvalid || s_tready) begin
        if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_flight = pending_vertices.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= in_flight.data;
          s_tlast  <= in_flight.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (want_results.size() == 0) begin
          $error("result transaction with no result pending");
          errors++;
        end else begin
          oldest = want_results.pop_front();
          check_field("has_vertex", oldest.has_vertex, m_tuser);
          check_field("vertex_index", oldest.vertex_index, m_tdata[15:0]);
          check_field("run_start", oldest.run_start, m_tdata[31:16]);
          check_field("delta_x", $signed(oldest.delta_x), $signed(m_tdata[39:32]));
          check_field("delta_y", $signed(oldest.delta_y), $signed(m_tdata[47:40]));
          check_field("delta_z", $signed(oldest.delta_z), $signed(m_tdata[55:48]));
          check_field("run_end", oldest.run_end, m_tdata[56]);
          check_field("run_length", oldest.run_length, m_tdata[72:57]);
          check_field("frame_done", oldest.frame_done, m_tlast);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle  = 20;
    recv_stall = 73;
    queue_directed();
    queue_random(RAND_PER_PHASE);
    // sender holds off here until every result is out
    wait_drained();
    send_idle  = 73;
    recv_stall = 20;
    queue_random(RAND_PER_PHASE);
    wait_drained();
    send_idle  = 0;
    recv_stall = 0;
    queue_random(RAND_PER_PHASE);
    wait_drained();
    if (errors == 0 && want_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/qdre_pkg.sv
design/qdre_quant.sv
design/qdre_run.sv
design/qdre_outq.sv
design/quantized_delta_run_encoder_core.sv
test/testbench.sv
